// ===== rtl/kmdr_pkg.sv =====
package kmdr_pkg;

   localparam int ROW_W      = 4;
   localparam int COL_W      = 5;
   localparam int CODE_W     = 8;
   localparam int CNT_W      = 4;
   localparam int FILL_W     = 3;
   localparam int SLOT_STORE = 6;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   // modifier usages 0xE0..0xE7 share their upper five bits
   localparam logic [4:0] MOD_PREFIX = 5'b11100;

   localparam logic [CNT_W-1:0] THRESHOLD_RESET = 4'd4;

   typedef logic [CODE_W-1:0] code_type;

endpackage

// ===== rtl/kmdr_count_mem.sv =====
module kmdr_count_mem
   import kmdr_pkg::*;
#(
   parameter int DEPTH = 84,
   parameter int AW    = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [CNT_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [CNT_W-1:0] rd_data,
   output logic             busy
);

   logic [CNT_W-1:0] mem [DEPTH];
   logic [CNT_W-1:0] rd_data_ff;
   logic             clr_busy_ff, clr_busy_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // same-address write in this cycle is forwarded to the read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

// ===== rtl/key_matrix_debounce_report.sv =====
// Keyboard matrix debounce and HID boot report builder.
//
// req channel: one matrix key sample per item (row, column, pressed level,
// usage code); req_tlast marks the last sample of a scan. Each key has a
// debounce counter; once it reaches the threshold the key is reported.
// rsp channel: one 7-byte boot report (modifier byte, six key slots) plus
// the filled-slot count, emitted for each item with req_tlast set.
// csr channel: writes the 4-bit debounce threshold (reset value 4); always
// ready. Write it only while the block is idle; the block itself does not enforce this.
//
// Throughput: one item per cycle while the update stage is not held (see
// Stall). The counter memory is read at the accept edge of a report's last
// item; the update stage then writes the report into the output register.
// Reset: the counter memory is cleared one entry per cycle, all ROWS*COLUMNS
// entries (84 by default); req_tready stays low until that is done.
// Stall: the output register holds the report while rsp_tready is low;
// samples keep flowing until a second report is ready to leave, then the
// update stage and req_tready hold.
module key_matrix_debounce_report
   import kmdr_pkg::*;
#(
   parameter int ROWS    = 6,
   parameter int COLUMNS = 14,
   parameter int SLOTS   = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [3:0] row, [8:4] column, [9] pressed, [17:10] key_code, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] modifier_bits, [15:8] slot_zero .. [55:48] slot_five,
   // [58:56] filled_slots, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_data
);

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ROW_W-1:0]  req_row;
   logic [COL_W-1:0]  req_column;
   logic              req_pressed;
   code_type          req_code;
   logic              req_in_range;
   logic [AW-1:0]     req_idx;
   logic              req_accept;

   logic [CNT_W-1:0]  thr_ff;

   logic              s1_valid_ff;
   logic              s1_in_range_ff;
   logic [AW-1:0]     s1_idx_ff;
   logic              s1_pressed_ff;
   code_type          s1_code_ff;
   logic              s1_last_ff;
   logic              s1_adv;

   logic [CNT_W-1:0]  cnt;
   logic              reached;
   logic [CNT_W-1:0]  cnt_new;
   logic              report;
   logic              is_mod;
   logic              mem_busy;

   logic [7:0]        mods_ff, mods_in;
   code_type          slots_ff [SLOT_STORE];
   code_type          slots_in [SLOT_STORE];
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign req_row      = req_tdata[3:0];
   assign req_column   = req_tdata[8:4];
   assign req_pressed  = req_tdata[9];
   assign req_code     = req_tdata[17:10];
   assign req_in_range = (32'(req_row) < ROWS) && (32'(req_column) < COLUMNS);
   assign req_idx      = AW'(32'(req_row) * COLUMNS + 32'(req_column));

   assign s1_adv     = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !mem_busy && (!s1_valid_ff || s1_adv);
   assign req_accept = req_tvalid && req_tready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   kmdr_count_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_count_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (s1_adv && s1_in_range_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (cnt_new),
      .rd_en   (req_accept && req_in_range),
      .rd_addr (req_idx),
      .rd_data (cnt),
      .busy    (mem_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_in_range_ff <= req_in_range;
         s1_idx_ff      <= req_idx;
         s1_pressed_ff  <= req_pressed;
         s1_code_ff     <= req_code;
         s1_last_ff     <= req_tlast;
      end
   end

   assign reached = cnt >= thr_ff;
   assign report  = s1_in_range_ff && s1_pressed_ff && reached;
   assign is_mod  = s1_code_ff[7:3] == MOD_PREFIX;

   always_comb begin
      if (!s1_pressed_ff) begin
         cnt_new = '0;
      end else if (reached) begin
         cnt_new = cnt;
      end else begin
         cnt_new = cnt + 1'b1;
      end
   end

   always_comb begin
      mods_in = mods_ff;
      fill_in = fill_ff;
      for (int k = 0; k < SLOT_STORE; k++) begin
         slots_in[k] = slots_ff[k];
      end
      if (report && is_mod) begin
         mods_in[s1_code_ff[2:0]] = 1'b1;
      end
      if (report && !is_mod && (32'(fill_ff) < SLOTS)) begin
         fill_in = fill_ff + 1'b1;
         for (int k = 0; k < SLOT_STORE; k++) begin
            if (fill_ff == FILL_W'(k)) begin
               slots_in[k] = s1_code_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff <= '0;
         fill_ff <= '0;
         for (int k = 0; k < SLOT_STORE; k++) begin
            slots_ff[k] <= '0;
         end
      end else if (s1_adv) begin
         if (s1_last_ff) begin
            mods_ff <= '0;
            fill_ff <= '0;
            for (int k = 0; k < SLOT_STORE; k++) begin
               slots_ff[k] <= '0;
            end
         end else begin
            mods_ff <= mods_in;
            fill_ff <= fill_in;
            for (int k = 0; k < SLOT_STORE; k++) begin
               slots_ff[k] <= slots_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         rsp_data_ff <= {5'd0, fill_in, slots_in[5], slots_in[4], slots_in[3],
                         slots_in[2], slots_in[1], slots_in[0], mods_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= SLOTS)
      else $error("pending slot count above SLOTS");

   a_rsp_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_data_ff[58:56]) <= SLOTS))
      else $error("reported slot count above SLOTS");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      mem_busy |-> !req_tready)
      else $error("item accepted during counter clear");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> (s1_last_ff && rsp_valid_ff && !rsp_tready))
      else $error("update stage held without a blocked report");

endmodule
